/* rtl/gpt_pkg.sv */
// Shared types and constants for the gate pulse prefix table.
// No dependencies; imported by every module of the block.
package gpt_pkg;

    // Default sizes (top-level parameters take these)
    localparam int DEF_MAX_STEPS    = 64;
    localparam int DEF_MAX_DIVISION = 8;

    // Steps examined per scan cycle
    localparam int LANES     = 8;
    localparam int LOG_LANES = 3;

    // Fixed field widths
    localparam int CFG_DATA_W   = 7;
    localparam int STEP_IDX_W   = 6;
    localparam int PHASE_W      = 9;
    localparam int COUNT_OUT_W  = 7;
    localparam int DIST_OUT_W   = 10;
    localparam int PERIOD_OUT_W = 10;

    // Register indexes
    localparam logic CFG_LANE_LENGTH   = 1'b0;
    localparam logic CFG_STEP_DIVISION = 1'b1;

    // Request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;    // latch item, apply a write, clear accumulators
        logic scan;    // accumulate one row of steps
        logic finish;  // form the result into the output register
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic last_row;  // current row is the last one inside the lane
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage

/* rtl/gpt_ctrl.sv */
// Sequencing controller for the gate pulse prefix table.
// Depends on gpt_pkg (command and status structs).
module gpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gpt_pkg::t_dp_stat i_stat,
    output gpt_pkg::t_dp_cmd  o_cmd
);
    import gpt_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.last_row) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Take a new item only between scans
    assign o_in_stall = (r_state != ST_IDLE);

endmodule

/* rtl/gpt_datapath.sv */
// Datapath: gate bit rows, configuration, row scan accumulators and output register.
// Depends on gpt_pkg; driven by gpt_ctrl commands.
module gpt_datapath #(
    parameter int MAX_STEPS    = gpt_pkg::DEF_MAX_STEPS,
    parameter int MAX_DIVISION = gpt_pkg::DEF_MAX_DIVISION
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [gpt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input item
    input  logic                                i_req_type,
    input  logic [gpt_pkg::STEP_IDX_W-1:0]      i_step_index,
    input  logic                                i_gate_on,
    input  logic [gpt_pkg::PHASE_W-1:0]         i_phase,
    // control
    input  gpt_pkg::t_dp_cmd                    i_cmd,
    output gpt_pkg::t_dp_stat                   o_stat,
    // result item
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [gpt_pkg::COUNT_OUT_W-1:0]     o_pulses_before,
    output logic [gpt_pkg::DIST_OUT_W-1:0]      o_prev_gated_distance,
    output logic [gpt_pkg::COUNT_OUT_W-1:0]     o_pulses_per_loop,
    output logic [gpt_pkg::PERIOD_OUT_W-1:0]    o_period_steps,
    output logic                                o_phase_valid
);
    import gpt_pkg::*;

    localparam int NROWS  = (MAX_STEPS + LANES - 1) / LANES;
    localparam int RW     = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int SW     = RW + LOG_LANES + 1;
    localparam int LL_W   = $clog2(MAX_STEPS + 1);
    localparam int DV_W   = $clog2(MAX_DIVISION + 1);
    localparam int CNT_W  = $clog2(MAX_STEPS + 1);
    localparam int PH_RAW = $clog2(NROWS * LANES * MAX_DIVISION + 1);
    localparam int PH_W   = (PH_RAW > PHASE_W + 1) ? PH_RAW : PHASE_W + 1;

    // Gate bits, one row of LANES steps per entry
    logic [LANES-1:0]   r_gate [NROWS];

    // Configuration
    logic [LL_W-1:0]    r_len;
    logic [DV_W-1:0]    r_div;

    // Latched item
    logic               r_req;
    logic [PHASE_W-1:0] r_ph;

    // Scan state and accumulators
    logic [RW-1:0]      r_row;
    logic [PH_W-1:0]    r_base;
    logic [CNT_W-1:0]   r_total;
    logic [CNT_W-1:0]   r_before;
    logic               r_any;
    logic [PH_W-1:0]    r_last;
    logic               r_any_b;
    logic [PH_W-1:0]    r_prev;

    // Output register
    logic                    r_o_valid;
    logic [COUNT_OUT_W-1:0]  r_o_before;
    logic [DIST_OUT_W-1:0]   r_o_dist;
    logic [COUNT_OUT_W-1:0]  r_o_total;
    logic [PERIOD_OUT_W-1:0] r_o_period;
    logic                    r_o_pvalid;

    // Row scan combinational results
    logic [LANES-1:0]   gated;
    logic [LANES-1:0]   gated_b;
    logic [PH_W-1:0]    lane_ph [LANES];
    logic [CNT_W-1:0]   row_cnt;
    logic [CNT_W-1:0]   row_cnt_b;
    logic               row_any;
    logic [PH_W-1:0]    row_last;
    logic               row_any_b;
    logic [PH_W-1:0]    row_prev;
    logic [SW-1:0]      next_start;

    // Final result terms
    logic [PH_W-1:0]    period;
    logic [PH_W-1:0]    ph_ext;
    logic               ph_ok;
    logic [PH_W:0]      gap_dist;

    // Examine one row of steps
    always_comb begin
        gated     = '0;
        gated_b   = '0;
        row_cnt   = '0;
        row_cnt_b = '0;
        row_any   = 1'b0;
        row_last  = '0;
        row_any_b = 1'b0;
        row_prev  = '0;
        for (int k = 0; k < LANES; k++) begin
            lane_ph[k] = r_base + PH_W'(r_div) * PH_W'(k);
            gated[k]   = r_gate[r_row][k] &&
                         (SW'({r_row, LOG_LANES'(k)}) < SW'(r_len));
            gated_b[k] = gated[k] && (lane_ph[k] < PH_W'(r_ph));
            row_cnt    = row_cnt + CNT_W'(gated[k]);
            row_cnt_b  = row_cnt_b + CNT_W'(gated_b[k]);
            if (gated[k]) begin
                row_any  = 1'b1;
                row_last = lane_ph[k];
            end
            if (gated_b[k]) begin
                row_any_b = 1'b1;
                row_prev  = lane_ph[k];
            end
        end
    end

    assign next_start      = (SW'(r_row) + SW'(1)) << LOG_LANES;
    assign o_stat.last_row = (next_start >= SW'(r_len)) || (r_row == RW'(NROWS - 1));
    assign o_stat.out_free = !r_o_valid || !i_out_stall;

    // Result terms
    assign period = PH_W'(r_len) * PH_W'(r_div);
    assign ph_ext = PH_W'(r_ph);
    assign ph_ok  = (r_req == REQ_QUERY) && (ph_ext < period);

    always_comb begin
        if (r_any_b) begin
            gap_dist = (PH_W + 1)'(ph_ext - r_prev);
        end else if (r_any) begin
            gap_dist = (PH_W + 1)'(ph_ext) + (PH_W + 1)'(period) - (PH_W + 1)'(r_last);
        end else begin
            gap_dist = '0;
        end
    end

    // Configuration registers, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LL_W'(1);
            r_div <= DV_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LANE_LENGTH: begin
                    if (i_cfg_data == '0) begin
                        r_len <= LL_W'(1);
                    end else if (32'(i_cfg_data) > 32'(MAX_STEPS)) begin
                        r_len <= LL_W'(MAX_STEPS);
                    end else begin
                        r_len <= LL_W'(i_cfg_data);
                    end
                end
                CFG_STEP_DIVISION: begin
                    if (i_cfg_data == '0) begin
                        r_div <= DV_W'(1);
                    end else if (32'(i_cfg_data) > 32'(MAX_DIVISION)) begin
                        r_div <= DV_W'(MAX_DIVISION);
                    end else begin
                        r_div <= DV_W'(i_cfg_data);
                    end
                end
                default: begin
                    r_len <= r_len;
                end
            endcase
        end
    end

    // Gate bit rows: cleared at reset, written on a write item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NROWS; r++) begin
                r_gate[r] <= '0;
            end
        end else if (i_cmd.load && (i_req_type == REQ_WRITE) &&
                     (32'(i_step_index) < 32'(MAX_STEPS))) begin
            r_gate[RW'(i_step_index >> LOG_LANES)][i_step_index[LOG_LANES-1:0]] <= i_gate_on;
        end
    end

    // Item latch and scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req_type;
            r_ph     <= i_phase;
            r_row    <= '0;
            r_base   <= '0;
            r_total  <= '0;
            r_before <= '0;
            r_any    <= 1'b0;
            r_last   <= '0;
            r_any_b  <= 1'b0;
            r_prev   <= '0;
        end else if (i_cmd.scan) begin
            r_row    <= r_row + RW'(1);
            r_base   <= r_base + (PH_W'(r_div) << LOG_LANES);
            r_total  <= r_total + row_cnt;
            r_before <= r_before + row_cnt_b;
            if (row_any) begin
                r_any  <= 1'b1;
                r_last <= row_last;
            end
            if (row_any_b) begin
                r_any_b <= 1'b1;
                r_prev  <= row_prev;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_before <= ph_ok ? COUNT_OUT_W'(r_before) : '0;
            r_o_dist   <= ph_ok ? DIST_OUT_W'(gap_dist) : '0;
            r_o_total  <= COUNT_OUT_W'(r_total);
            r_o_period <= PERIOD_OUT_W'(period);
            r_o_pvalid <= ph_ok;
        end
    end

    assign o_out_valid           = r_o_valid;
    assign o_pulses_before       = r_o_before;
    assign o_prev_gated_distance = r_o_dist;
    assign o_pulses_per_loop     = r_o_total;
    assign o_period_steps        = r_o_period;
    assign o_phase_valid         = r_o_pvalid;

endmodule

/* rtl/gate_pulse_prefix_table.sv */
// Gate pulse prefix table, top level. Depends on gpt_pkg, gpt_ctrl, gpt_datapath.
//
// Every item (a gate write or a phase query) yields one result item. An item
// is taken in the idle state, then the gate bits are scanned eight steps per
// cycle up to the lane length, then the finish state forms the result once
// the output register is free. The next item is taken only after the last
// one has left the finish state. A finished result waits in the output
// register while the next item is already taken and scanned. Gate bits are
// cleared by reset with no extra pass; configuration must be written while
// no item is in flight.
module gate_pulse_prefix_table #(
    parameter int MAX_STEPS    = gpt_pkg::DEF_MAX_STEPS,
    parameter int MAX_DIVISION = gpt_pkg::DEF_MAX_DIVISION
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [gpt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic [gpt_pkg::STEP_IDX_W-1:0]      i_step_index,
    input  logic                                i_gate_on,
    input  logic [gpt_pkg::PHASE_W-1:0]         i_phase,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [gpt_pkg::COUNT_OUT_W-1:0]     o_pulses_before,
    output logic [gpt_pkg::DIST_OUT_W-1:0]      o_prev_gated_distance,
    output logic [gpt_pkg::COUNT_OUT_W-1:0]     o_pulses_per_loop,
    output logic [gpt_pkg::PERIOD_OUT_W-1:0]    o_period_steps,
    output logic                                o_phase_valid
);
    import gpt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    gpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Storage, scan and result
    gpt_datapath #(
        .MAX_STEPS    (MAX_STEPS),
        .MAX_DIVISION (MAX_DIVISION)
    ) u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_req_type            (i_req_type),
        .i_step_index          (i_step_index),
        .i_gate_on             (i_gate_on),
        .i_phase               (i_phase),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .i_out_stall           (i_out_stall),
        .o_out_valid           (o_out_valid),
        .o_pulses_before       (o_pulses_before),
        .o_prev_gated_distance (o_prev_gated_distance),
        .o_pulses_per_loop     (o_pulses_per_loop),
        .o_period_steps        (o_period_steps),
        .o_phase_valid         (o_phase_valid)
    );

endmodule

/* tb/gate_pulse_prefix_table_test.sv */
// Self-checking testbench for gate_pulse_prefix_table: gate writes and phase queries.
// Needs gpt_pkg and the gate_pulse_prefix_table RTL; everything else is self-contained.
`timescale 1ns / 1ps

module gate_pulse_prefix_table_test;
    import gpt_pkg::*;

    localparam int NUM_STEPS      = 64;
    localparam int NUM_DIV        = 8;
    localparam int ITEMS_PER_SET  = 64;
    localparam int NUM_SETTINGS   = 10;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic                  req;
        logic [STEP_IDX_W-1:0] step;
        logic                  gate;
        logic [PHASE_W-1:0]    phase;
    } t_gate_req;

    typedef struct {
        logic [COUNT_OUT_W-1:0]  cnt_before;
        logic [DIST_OUT_W-1:0]   distance;
        logic [COUNT_OUT_W-1:0]  total;
        logic [PERIOD_OUT_W-1:0] period;
        logic                    valid;
    } t_gate_res;

    // Block ports
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic                    i_cfg_index = CFG_LANE_LENGTH;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_req_type = REQ_WRITE;
    logic [STEP_IDX_W-1:0]   i_step_index = '0;
    logic                    i_gate_on = 1'b0;
    logic [PHASE_W-1:0]      i_phase = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [COUNT_OUT_W-1:0]  o_pulses_before;
    logic [DIST_OUT_W-1:0]   o_prev_gated_distance;
    logic [COUNT_OUT_W-1:0]  o_pulses_per_loop;
    logic [PERIOD_OUT_W-1:0] o_period_steps;
    logic                    o_phase_valid;

    // Shadow copy of the block's state
    bit          gate_mem [NUM_STEPS];
    int unsigned lane_len_q = 1;
    int unsigned div_q = 1;

    // Stimulus and expectations
    t_gate_req pending_reqs [$];
    t_gate_res expected_results [$];
    t_gate_req next_req;

    bit          calm = 1'b0;
    bit          in_taken = 1'b0;
    int unsigned in_gap = 0;
    int unsigned out_hold = 0;
    int unsigned idle_cycles = 0;

    int unsigned n_results = 0;
    int unsigned n_queries = 0;
    int unsigned n_writes = 0;
    int unsigned n_outside = 0;
    int unsigned n_settings = 1;
    int unsigned n_errors = 0;

    gate_pulse_prefix_table i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_req_type            (i_req_type),
        .i_step_index          (i_step_index),
        .i_gate_on             (i_gate_on),
        .i_phase               (i_phase),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_pulses_before       (o_pulses_before),
        .o_prev_gated_distance (o_prev_gated_distance),
        .o_pulses_per_loop     (o_pulses_per_loop),
        .o_period_steps        (o_period_steps),
        .o_phase_valid         (o_phase_valid)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_value(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Applies one item to the shadow state and forms its result
    function automatic t_gate_res predict_item(t_gate_req r);
        t_gate_res   res;
        int unsigned period;
        int unsigned total;
        int unsigned before_cnt;
        int unsigned prev_p;
        int unsigned last_p;
        int unsigned p;
        bit          seen;
        bit          seen_before;
        total = 0;
        before_cnt = 0;
        prev_p = 0;
        last_p = 0;
        seen = 1'b0;
        seen_before = 1'b0;
        if (r.req == REQ_WRITE)
            gate_mem[r.step] = r.gate;
        period = lane_len_q * div_q;
        for (p = 0; p < period; p++) begin
            if ((p % div_q) == 0 && gate_mem[p / div_q]) begin
                if (p < r.phase) begin
                    before_cnt++;
                    prev_p = p;
                    seen_before = 1'b1;
                end
                total++;
                last_p = p;
                seen = 1'b1;
            end
        end
        res.total = total[COUNT_OUT_W-1:0];
        res.period = period[PERIOD_OUT_W-1:0];
        res.cnt_before = '0;
        res.distance = '0;
        res.valid = 1'b0;
        if (r.req == REQ_QUERY && r.phase < period) begin
            res.valid = 1'b1;
            res.cnt_before = before_cnt[COUNT_OUT_W-1:0];
            if (seen_before)
                res.distance = DIST_OUT_W'(r.phase - prev_p);
            else if (seen)
                res.distance = DIST_OUT_W'(r.phase + period - last_p);
        end
        return res;
    endfunction

    // Random item shaped by the current lane: mostly in-lane steps and in-period phases
    function automatic t_gate_req random_req();
        t_gate_req   r;
        int unsigned period;
        period = lane_len_q * div_q;
        r.req = ($urandom_range(0, 99) < 35) ? REQ_WRITE : REQ_QUERY;
        r.gate = ($urandom_range(0, 9) < 6);
        if ($urandom_range(0, 9) < 8)
            r.step = STEP_IDX_W'($urandom_range(0, lane_len_q - 1));
        else
            r.step = STEP_IDX_W'($urandom_range(0, NUM_STEPS - 1));
        if ($urandom_range(0, 9) >= 8)
            r.phase = PHASE_W'($urandom_range(0, 511));
        else if ($urandom_range(0, 3) == 0)
            r.phase = PHASE_W'($urandom_range(0, lane_len_q - 1) * div_q +
                               $urandom_range(0, 1));
        else
            r.phase = PHASE_W'($urandom_range(0, period - 1));
        return r;
    endfunction

    task automatic push_write(int unsigned step, bit on);
        t_gate_req r;
        r.req = REQ_WRITE;
        r.step = STEP_IDX_W'(step);
        r.gate = on;
        r.phase = PHASE_W'($urandom_range(0, 511));
        pending_reqs.push_back(r);
    endtask

    task automatic push_query(int unsigned ph);
        t_gate_req r;
        r.req = REQ_QUERY;
        r.step = STEP_IDX_W'($urandom_range(0, NUM_STEPS - 1));
        r.gate = 1'($urandom_range(0, 1));
        r.phase = PHASE_W'(ph);
        pending_reqs.push_back(r);
    endtask

    // One register write; the shadow copy follows with the same clamping
    task automatic write_reg(logic idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LANE_LENGTH)
            lane_len_q = clamp_value(value, NUM_STEPS);
        else
            div_q = clamp_value(value, NUM_DIV);
    endtask

    // Block until every queued item is taken and every result has come back
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid);
        while (expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Item driver and result-side stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || in_taken) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    next_req = pending_reqs.pop_front();
                    i_req_type <= next_req.req;
                    i_step_index <= next_req.step;
                    i_gate_on <= next_req.gate;
                    i_phase <= next_req.phase;
                    i_in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 4) == 0)
                        in_gap = $urandom_range(1, 9);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (calm) begin
                out_hold = 0;
                i_out_stall <= 1'b0;
            end else if (out_hold > 0) begin
                out_hold--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                out_hold = $urandom_range(1, 9) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Monitor: predict on input acceptance, check on result acceptance
    always @(posedge i_clk) begin
        t_gate_req taken_req;
        t_gate_res exp_res;
        t_gate_res got_res;
        bit        out_taken;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = i_in_valid && !o_in_stall;
            out_taken = o_out_valid && !i_out_stall;
            if (in_taken) begin
                taken_req.req = i_req_type;
                taken_req.step = i_step_index;
                taken_req.gate = i_gate_on;
                taken_req.phase = i_phase;
                exp_res = predict_item(taken_req);
                expected_results.push_back(exp_res);
                if (taken_req.req == REQ_WRITE)
                    n_writes++;
                else begin
                    n_queries++;
                    if (!exp_res.valid)
                        n_outside++;
                end
            end
            if (out_taken) begin
                got_res.cnt_before = o_pulses_before;
                got_res.distance = o_prev_gated_distance;
                got_res.total = o_pulses_per_loop;
                got_res.period = o_period_steps;
                got_res.valid = o_phase_valid;
                if (expected_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= REPORT_LIMIT) begin
                        $display("unexpected result:");
                        $display("    got before=%0d dist=%0d total=%0d period=%0d valid=%0d",
                                 got_res.cnt_before, got_res.distance, got_res.total,
                                 got_res.period, got_res.valid);
                    end
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got_res.cnt_before !== exp_res.cnt_before ||
                        got_res.distance !== exp_res.distance ||
                        got_res.total !== exp_res.total ||
                        got_res.period !== exp_res.period ||
                        got_res.valid !== exp_res.valid) begin
                        n_errors++;
                        if (n_errors <= REPORT_LIMIT) begin
                            $display("result %0d mismatch:", n_results);
                            $display("    exp before=%0d dist=%0d total=%0d period=%0d valid=%0d",
                                     exp_res.cnt_before, exp_res.distance, exp_res.total,
                                     exp_res.period, exp_res.valid);
                            $display("    got before=%0d dist=%0d total=%0d period=%0d valid=%0d",
                                     got_res.cnt_before, got_res.distance, got_res.total,
                                     got_res.period, got_res.valid);
                        end
                    end
                end
                n_results++;
            end
            if (in_taken || out_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Watchdog: too long with no item moving on either side
    initial begin
        wait (i_rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
            @(negedge i_clk);
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("gate_pulse_prefix_table_test: FAIL");
        $finish;
    end

    // Stimulus sequence
    initial begin
        int unsigned lane_set [NUM_SETTINGS];
        int unsigned div_set [NUM_SETTINGS];
        lane_set = '{0, 8, 1, 64, 5, 33, 0, 0, 127, 100};
        div_set  = '{0, 3, 8, 1, 7, 2, 0, 0, 4, 12};
        foreach (gate_mem[k])
            gate_mem[k] = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset lane: one step, one phase per step
        push_query(0);
        push_write(0, 1'b1);
        push_query(0);
        push_query(1);
        push_query(511);
        push_write(63, 1'b1);
        push_query(0);
        wait_quiet();

        // Over-range writes clamp to the largest cycle, 512 phases
        write_reg(CFG_LANE_LENGTH, 127);
        write_reg(CFG_STEP_DIVISION, 15);
        n_settings++;
        push_query(0);
        push_query(511);
        push_query(504);
        push_query(505);
        push_write(32, 1'b1);
        push_query(256);
        push_query(257);
        push_write(63, 1'b0);
        push_query(0);
        push_write(0, 1'b0);
        push_write(32, 1'b0);
        push_query(300);
        push_write(17, 1'b1);
        push_query(137);
        push_query(136);
        wait_quiet();

        // Random items, one register setting each; the last runs without idling
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            if (s == 6 || s == 7) begin
                lane_set[s] = $urandom_range(1, 64);
                div_set[s] = $urandom_range(0, 15);
            end
            write_reg(CFG_LANE_LENGTH, lane_set[s]);
            write_reg(CFG_STEP_DIVISION, div_set[s]);
            n_settings++;
            if (s == NUM_SETTINGS - 1) begin
                calm = 1'b1;
                in_gap = 0;
            end
            for (int n = 0; n < ITEMS_PER_SET; n++)
                pending_reqs.push_back(random_req());
            wait_quiet();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            n_errors++;
            $display("%0d expected results never arrived", expected_results.size());
        end

        $display("covered %0d items: %0d gate writes, %0d queries (%0d outside the cycle)",
                 n_writes + n_queries, n_writes, n_queries, n_outside);
        $display("across %0d lane settings; %0d results checked, %0d mismatches",
                 n_settings, n_results, n_errors);
        if (n_errors == 0)
            $display("gate_pulse_prefix_table_test: PASS");
        else
            $display("gate_pulse_prefix_table_test: FAIL");
        $finish;
    end

endmodule
